/* sv/soc_pkg.sv */
// shared types and constants for the segment obstacle collision check
`default_nettype none

package soc_pkg;

    localparam int MAX_OBSTACLES = 16;
    localparam int COORD_BITS    = 16;
    localparam int COUNT_BITS    = 5;
    localparam int SLOT_BITS     = 4;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    // pipeline depth of the straddle unit from issue to the hit accumulator input
    localparam int CHECK_LAT = 2;

    localparam int CNT_W   = $clog2(MAX_OBSTACLES + 1);
    localparam int DRAIN_W = $clog2(CHECK_LAT + 1);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [CROSS_W-1:0]    t_cross;

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_seg;

    typedef struct packed {
        logic clr;
        logic issue;
    } t_check_ctl;

    function automatic t_diff coord_diff(input t_coord a, input t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

    function automatic t_prod diff_mul(input t_diff a, input t_diff b);
        return t_prod'(a) * t_prod'(b);
    endfunction

endpackage

`default_nettype wire

/* sv/soc_cell.sv */
// one obstacle storage cell of the rotating ring
`default_nettype none

module soc_cell (
    input  wire logic          i_clk,
    input  wire logic          i_load_en,
    input  wire soc_pkg::t_seg i_load_seg,
    input  wire logic          i_shift_en,
    input  wire soc_pkg::t_seg i_next_seg,
    output soc_pkg::t_seg      o_seg
);

    soc_pkg::t_seg r_seg;

    // load and shift never overlap: loads only while the ring is parked
    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_seg <= i_load_seg;
        end else if (i_shift_en) begin
            r_seg <= i_next_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

`default_nettype wire

/* sv/soc_check.sv */
// pipelined straddle test of the path against one obstacle per cycle
`default_nettype none

module soc_check (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire soc_pkg::t_check_ctl i_ctl,
    input  wire soc_pkg::t_seg       i_path,
    input  wire soc_pkg::t_seg       i_obst,
    output logic                     o_hit
);

    // stage 1: coordinate differences
    logic           r_v1;
    soc_pkg::t_diff r_px, r_py, r_ox, r_oy;
    soc_pkg::t_diff r_sxa, r_sya, r_exa, r_eya;
    soc_pkg::t_diff r_axs, r_ays, r_bxs, r_bys;

    // stage 2: products
    logic           r_v2;
    soc_pkg::t_prod r_s1a, r_s1b, r_s2a, r_s2b;
    soc_pkg::t_prod r_t1a, r_t1b, r_t2a, r_t2b;

    logic r_acc;

    soc_pkg::t_cross s1, s2, t1, t2;
    logic            path_straddle, obst_straddle, hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px  <= soc_pkg::coord_diff(i_path.ex, i_path.sx);
        r_py  <= soc_pkg::coord_diff(i_path.ey, i_path.sy);
        r_ox  <= soc_pkg::coord_diff(i_obst.ex, i_obst.sx);
        r_oy  <= soc_pkg::coord_diff(i_obst.ey, i_obst.sy);
        r_sxa <= soc_pkg::coord_diff(i_obst.sx, i_path.sx);
        r_sya <= soc_pkg::coord_diff(i_obst.sy, i_path.sy);
        r_exa <= soc_pkg::coord_diff(i_obst.ex, i_path.sx);
        r_eya <= soc_pkg::coord_diff(i_obst.ey, i_path.sy);
        r_axs <= soc_pkg::coord_diff(i_path.sx, i_obst.sx);
        r_ays <= soc_pkg::coord_diff(i_path.sy, i_obst.sy);
        r_bxs <= soc_pkg::coord_diff(i_path.ex, i_obst.sx);
        r_bys <= soc_pkg::coord_diff(i_path.ey, i_obst.sy);
    end

    always_ff @(posedge i_clk) begin
        r_s1a <= soc_pkg::diff_mul(r_px, r_sya);
        r_s1b <= soc_pkg::diff_mul(r_py, r_sxa);
        r_s2a <= soc_pkg::diff_mul(r_px, r_eya);
        r_s2b <= soc_pkg::diff_mul(r_py, r_exa);
        r_t1a <= soc_pkg::diff_mul(r_ox, r_ays);
        r_t1b <= soc_pkg::diff_mul(r_oy, r_axs);
        r_t2a <= soc_pkg::diff_mul(r_ox, r_bys);
        r_t2b <= soc_pkg::diff_mul(r_oy, r_bxs);
    end

    // stage 3: cross products and sign tests
    always_comb begin
        s1 = soc_pkg::t_cross'(r_s1a) - soc_pkg::t_cross'(r_s1b);
        s2 = soc_pkg::t_cross'(r_s2a) - soc_pkg::t_cross'(r_s2b);
        t1 = soc_pkg::t_cross'(r_t1a) - soc_pkg::t_cross'(r_t1b);
        t2 = soc_pkg::t_cross'(r_t2a) - soc_pkg::t_cross'(r_t2b);
        // same strict side means no straddle, a zero always straddles
        path_straddle = !(((s1 > 0) && (s2 > 0)) || ((s1 < 0) && (s2 < 0)));
        obst_straddle = !(((t1 > 0) && (t2 > 0)) || ((t1 < 0) && (t2 < 0)));
        hit = r_v2 && path_straddle && obst_straddle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 1'b0;
        end else if (i_ctl.clr) begin
            r_acc <= 1'b0;
        end else if (hit) begin
            r_acc <= 1'b1;
        end
    end

    assign o_hit = r_acc;

endmodule

`default_nettype wire

/* sv/segment_obstacle_collision_check.sv */
// top level: obstacle ring, straddle unit, query sequencer and output register
// load beats are accepted back to back while idle
// query: the ring rotates one obstacle per cycle through the sweep, then the
//   check pipeline drains before the result is registered
// a new beat can be accepted once the sequencer is back in idle, which it enters as the result is registered
// synchronous active-low reset clears the sequencer, count register and output valid flag
`default_nettype none

module segment_obstacle_collision_check (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_kind,
    input  wire logic [soc_pkg::SLOT_BITS-1:0]       i_slot,
    input  wire logic signed [soc_pkg::COORD_BITS-1:0] i_first_x,
    input  wire logic signed [soc_pkg::COORD_BITS-1:0] i_first_y,
    input  wire logic signed [soc_pkg::COORD_BITS-1:0] i_second_x,
    input  wire logic signed [soc_pkg::COORD_BITS-1:0] i_second_y,
    // output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_valid_res,
    // obstacle count register
    input  wire logic                                i_cfg_we,
    input  wire logic [soc_pkg::COUNT_BITS-1:0]      i_cfg_data
);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                      r_state, n_state;
    logic [soc_pkg::CNT_W-1:0]       r_k, n_k;
    logic [soc_pkg::DRAIN_W-1:0]     r_drain, n_drain;
    logic [soc_pkg::COUNT_BITS-1:0]  r_obst_count;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_res, n_out_res;
    soc_pkg::t_seg                   r_query;

    logic                            in_beat;
    logic                            load_beat;
    logic                            query_beat;
    logic                            out_free;
    logic                            hit;
    soc_pkg::t_seg                   in_seg;
    soc_pkg::t_check_ctl             check_ctl;
    soc_pkg::t_seg                   cell_seg [soc_pkg::MAX_OBSTACLES];

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_beat    = i_in_valid && !o_in_stall;
    assign load_beat  = in_beat && (i_kind == soc_pkg::KIND_LOAD);
    assign query_beat = in_beat && (i_kind == soc_pkg::KIND_QUERY);

    // output register can take a new result when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        in_seg.sx = i_first_x;
        in_seg.sy = i_first_y;
        in_seg.ex = i_second_x;
        in_seg.ey = i_second_y;
    end

    // count register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obst_count <= '0;
        end else if (i_cfg_we) begin
            r_obst_count <= i_cfg_data;
        end
    end

    // query path segment is held for the whole sweep
    always_ff @(posedge i_clk) begin
        if (query_beat) begin
            r_query <= in_seg;
        end
    end

    // obstacle ring: cell i takes cell i+1 on each sweep cycle, cell 0 feeds the
    // check unit, and a full turn of MAX_OBSTACLES shifts parks every slot back
    for (genvar gi = 0; gi < soc_pkg::MAX_OBSTACLES; gi++) begin : g_cell
        localparam int NEXT = (gi + 1) % soc_pkg::MAX_OBSTACLES;
        logic load_en;

        assign load_en = load_beat && (32'(i_slot) == gi);

        soc_cell u_cell (
            .i_clk      (i_clk),
            .i_load_en  (load_en),
            .i_load_seg (in_seg),
            .i_shift_en (r_state == ST_SWEEP),
            .i_next_seg (cell_seg[NEXT]),
            .o_seg      (cell_seg[gi])
        );
    end

    // only slots below the count register take part; a count above the
    // table size simply covers every slot
    always_comb begin
        check_ctl.clr   = query_beat;
        check_ctl.issue = (r_state == ST_SWEEP) && (32'(r_k) < 32'(r_obst_count));
    end

    soc_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (check_ctl),
        .i_path  (r_query),
        .i_obst  (cell_seg[0]),
        .o_hit   (hit)
    );

    // sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_drain     = r_drain;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_res   = r_out_res;
        unique case (r_state)
            ST_IDLE: begin
                if (query_beat) begin
                    n_state = ST_SWEEP;
                    n_k     = '0;
                end
            end
            ST_SWEEP: begin
                n_k = r_k + 1'b1;
                if (32'(r_k) == soc_pkg::MAX_OBSTACLES - 1) begin
                    n_state = ST_DRAIN;
                    n_drain = '0;
                end
            end
            ST_DRAIN: begin
                // let the last obstacle reach the hit accumulator
                n_drain = r_drain + 1'b1;
                if (32'(r_drain) == soc_pkg::CHECK_LAT - 1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_res   = !hit;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_res <= n_out_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_out_res;

endmodule

`default_nettype wire
